### rtl/cs_pkg.sv
`timescale 1ns / 1ps

package cs_pkg;

    // field and register widths
    localparam int CHROMA_IN_W   = 12;
    localparam int CHROMA_OUT_W  = 14;
    localparam int SUM_W         = 13;
    localparam int SUB_MODE_W    = 3;
    localparam int ROW_WIDTH_W   = 12;
    localparam int CFG_DATA_W    = 12;
    localparam int CFG_ADDR_W    = 1;
    localparam int MIN_ROW_WIDTH = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SUB_MODE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_WIDTH = 1'b1;

    // subsampling modes, codes above the last one fall back to pass-through
    localparam logic [SUB_MODE_W-1:0] MODE_444       = 3'd0;
    localparam logic [SUB_MODE_W-1:0] MODE_422       = 3'd1;
    localparam logic [SUB_MODE_W-1:0] MODE_411       = 3'd2;
    localparam logic [SUB_MODE_W-1:0] MODE_420_DROP  = 3'd3;
    localparam logic [SUB_MODE_W-1:0] MODE_420_VMEAN = 3'd4;
    localparam logic [SUB_MODE_W-1:0] MODE_420_FMEAN = 3'd5;

    // how the result stage forms the output value
    typedef enum logic [1:0] {
        CALC_PASS,
        CALC_VMEAN,
        CALC_FMEAN
    } calc_t;

endpackage

### rtl/chroma_subsampler.sv
`timescale 1ns / 1ps

// chroma subsampler: takes one signed chroma sample (1/16 units) per transaction in
// raster order and produces the subsampled stream in 1/64 units, selected by sub_mode:
// 4:4:4 pass, 4:2:2, 4:1:1, 4:2:0 drop, 4:2:0 vertical mean and 4:2:0 full mean (2x2
// block sum). frame_start marks column 0 of an even row. row_width is rounded down to a
// multiple of 16 and clamped to 16..MAX_ROW_WIDTH; the user must write it and sub_mode
// through the cfg port only while the block is idle, the block has no check for it. a
// new sample can be taken every clock while the result side keeps up; a result passes
// through stage 1 and the output register to m_*. while m_ready stays low one result
// waits in the output register and one in stage 1; s_ready drops once stage 1 is full,
// samples that produce no result go on being taken until then. the line buffer is a
// single MAX_ROW_WIDTH/2 x 13-bit memory with one write and one registered read port,
// written on even rows and read on the following odd row. the memory has no reset or
// clearing pass, so the mean modes need the even row of a pair before its odd row.
module chroma_subsampler #(
    parameter int MAX_ROW_WIDTH = 2048
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // input sample channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [cs_pkg::CHROMA_IN_W-1:0]   s_chroma_in,
    input  logic                                    s_frame_start,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [cs_pkg::CHROMA_OUT_W-1:0]  m_chroma_out,
    output logic                                    m_row_end,
    // configuration write port
    input  logic                                    cfg_wr_en,
    input  logic [cs_pkg::CFG_ADDR_W-1:0]           cfg_addr,
    input  logic [cs_pkg::CFG_DATA_W-1:0]           cfg_wdata
);
    import cs_pkg::*;

    // column counter width, line buffer geometry and width arithmetic width
    localparam int CW        = $clog2(MAX_ROW_WIDTH);
    localparam int BUF_DEPTH = MAX_ROW_WIDTH / 2;
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int MAX_EFF   = (MAX_ROW_WIDTH / 16) * 16;
    localparam int WW        = ($clog2(MAX_ROW_WIDTH + 1) > ROW_WIDTH_W) ?
                               $clog2(MAX_ROW_WIDTH + 1) : ROW_WIDTH_W;

    // configuration registers
    logic [SUB_MODE_W-1:0]  sub_mode_reg;
    logic [ROW_WIDTH_W-1:0] row_width_reg;

    // raster position and horizontal pair state
    logic [CW-1:0]                 col_reg, col_next;
    logic                          odd_row_reg, odd_row_next;
    logic signed [CHROMA_IN_W-1:0] pair_partial_reg, pair_partial_next;

    // stage 1: accepted sample that produces a result, waiting for line buffer data
    logic                          s1_valid_reg, s1_valid_next;
    calc_t                         s1_calc_reg;
    logic signed [CHROMA_IN_W-1:0] s1_x_reg;
    logic signed [CHROMA_IN_W-1:0] s1_pp_reg;
    logic                          s1_last_reg;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic signed [CHROMA_OUT_W-1:0] m_chroma_reg;
    logic                           m_row_end_reg;

    // handshake
    logic accept;
    logic out_adv;

    // stage 0 decode
    logic [CW-1:0]                 col_cur;
    logic                          odd_cur;
    logic [WW-1:0]                 col_x;
    logic [WW-1:0]                 w_raw, w_eff;
    logic                          at_end_1, at_end_2, at_end_4;
    logic                          emit;
    logic                          last;
    calc_t                         calc;
    logic                          buf_wr;
    logic signed [SUM_W-1:0]       buf_wr_data;
    logic [AW-1:0]                 buf_idx;
    logic signed [SUM_W-1:0]       buf_rd_data;

    // stage 1 arithmetic
    logic signed [SUM_W-1:0]        vsum;
    logic signed [CHROMA_OUT_W-1:0] fsum;
    logic signed [CHROMA_OUT_W-1:0] result;

    assign out_adv = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || out_adv;
    assign accept  = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_mode_reg  <= MODE_444;
            row_width_reg <= ROW_WIDTH_W'(MIN_ROW_WIDTH);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SUB_MODE:  sub_mode_reg  <= cfg_wdata[SUB_MODE_W-1:0];
                REG_ROW_WIDTH: row_width_reg <= cfg_wdata[ROW_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // effective row width: low four bits cleared, clamped to the supported range
    always_comb begin
        w_raw = WW'({row_width_reg[ROW_WIDTH_W-1:4], 4'b0000});
        if (w_raw < WW'(MIN_ROW_WIDTH)) begin
            w_eff = WW'(MIN_ROW_WIDTH);
        end else if (w_raw > WW'(MAX_EFF)) begin
            w_eff = WW'(MAX_EFF);
        end else begin
            w_eff = w_raw;
        end
    end

    // frame start puts the sample at column 0 of an even row
    assign col_cur  = s_frame_start ? '0 : col_reg;
    assign odd_cur  = s_frame_start ? 1'b0 : odd_row_reg;
    assign col_x    = WW'(col_cur);
    assign at_end_1 = col_x >= (w_eff - WW'(1));
    assign at_end_2 = col_x >= (w_eff - WW'(2));
    assign at_end_4 = col_x >= (w_eff - WW'(4));
    // one buffer entry per column pair
    assign buf_idx  = col_cur[AW:1];

    // per-mode decode of the incoming sample
    always_comb begin
        emit              = 1'b0;
        last              = 1'b0;
        calc              = CALC_PASS;
        buf_wr            = 1'b0;
        buf_wr_data       = SUM_W'(s_chroma_in);
        pair_partial_next = pair_partial_reg;
        case (sub_mode_reg)
            MODE_422: begin
                emit = !col_cur[0];
                last = at_end_2;
            end
            MODE_411: begin
                emit = (col_cur[1:0] == 2'b00);
                last = at_end_4;
            end
            MODE_420_DROP: begin
                emit = !odd_cur && !col_cur[0];
                last = at_end_2;
            end
            MODE_420_VMEAN: begin
                // even row stores the pick, odd row adds the sample below it
                if (!col_cur[0]) begin
                    if (!odd_cur) begin
                        buf_wr = 1'b1;
                    end else begin
                        emit = 1'b1;
                        calc = CALC_VMEAN;
                        last = at_end_2;
                    end
                end
            end
            MODE_420_FMEAN: begin
                // first of a pair is held, the second closes the pair
                if (!col_cur[0]) begin
                    pair_partial_next = s_chroma_in;
                end else if (!odd_cur) begin
                    buf_wr      = 1'b1;
                    buf_wr_data = SUM_W'(pair_partial_reg) + SUM_W'(s_chroma_in);
                end else begin
                    emit = 1'b1;
                    calc = CALC_FMEAN;
                    last = at_end_1;
                end
            end
            default: begin
                emit = 1'b1;
                last = at_end_1;
            end
        endcase
    end

    // row wrap
    always_comb begin
        if (at_end_1) begin
            col_next     = '0;
            odd_row_next = !odd_cur;
        end else begin
            col_next     = CW'(col_cur + 1'b1);
            odd_row_next = odd_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg          <= '0;
            odd_row_reg      <= 1'b0;
            pair_partial_reg <= '0;
        end else if (accept) begin
            col_reg          <= col_next;
            odd_row_reg      <= odd_row_next;
            pair_partial_reg <= pair_partial_next;
        end
    end

    // line buffer: written on even rows, read on every transaction, the read
    // data lines up with stage 1
    cs_line_buf #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (accept && buf_wr),
        .wr_addr (buf_idx),
        .wr_data (buf_wr_data),
        .rd_en   (accept),
        .rd_addr (buf_idx),
        .rd_data (buf_rd_data)
    );

    // stage 1 register: only samples that produce a result enter
    assign s1_valid_next = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_calc_reg <= calc;
            s1_x_reg    <= s_chroma_in;
            s1_pp_reg   <= pair_partial_reg;
            s1_last_reg <= last;
        end
    end

    // result arithmetic, exact in 1/64 units
    assign vsum = buf_rd_data + SUM_W'(s1_x_reg);
    assign fsum = CHROMA_OUT_W'(buf_rd_data) + CHROMA_OUT_W'(s1_pp_reg)
                + CHROMA_OUT_W'(s1_x_reg);

    always_comb begin
        case (s1_calc_reg)
            CALC_VMEAN: result = {vsum, 1'b0};
            CALC_FMEAN: result = fsum;
            default:    result = {s1_x_reg, 2'b00};
        endcase
    end

    // output register
    assign m_valid_next = s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && s1_valid_reg) begin
            m_chroma_reg  <= result;
            m_row_end_reg <= s1_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_chroma_out = m_chroma_reg;
    assign m_row_end    = m_row_end_reg;

endmodule

### rtl/cs_line_buf.sv
`timescale 1ns / 1ps

module cs_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [AW-1:0]                    wr_addr,
    input  logic signed [cs_pkg::SUM_W-1:0]  wr_data,
    input  logic                             rd_en,
    input  logic [AW-1:0]                    rd_addr,
    output logic signed [cs_pkg::SUM_W-1:0]  rd_data
);
    import cs_pkg::*;

    logic signed [SUM_W-1:0] mem [0:DEPTH-1];
    logic signed [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/cs_checker.sv
`timescale 1ns / 1ps

module cs_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic signed [cs_pkg::CHROMA_OUT_W-1:0]  m_chroma_out,
    input  logic                                    m_row_end,
    input  logic                                    cfg_wr_en,
    input  logic [cs_pkg::CFG_ADDR_W-1:0]           cfg_addr,
    input  logic [cs_pkg::CFG_DATA_W-1:0]           cfg_wdata
);
    import cs_pkg::*;

    // shadow of the mode register
    logic [SUB_MODE_W-1:0] sub_mode_reg;
    logic                  pass_mode;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_mode_reg <= MODE_444;
        end else if (cfg_wr_en && (cfg_addr == REG_SUB_MODE)) begin
            sub_mode_reg <= cfg_wdata[SUB_MODE_W-1:0];
        end
    end

    assign pass_mode = (sub_mode_reg != MODE_420_VMEAN) && (sub_mode_reg != MODE_420_FMEAN);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chroma_out) && $stable(m_row_end))
        else $error("result changed while stalled");

    // reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // picked samples are scaled by four
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && pass_mode |-> m_chroma_out[1:0] == 2'b00)
        else $error("picked sample not a multiple of four");

    // vertical mean is a two-sample sum scaled by two
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (sub_mode_reg == MODE_420_VMEAN) |-> !m_chroma_out[0])
        else $error("vertical mean result is odd");

endmodule

bind chroma_subsampler cs_checker u_cs_checker (.*);
